>>> hdl/dst_pkg.sv
// dst_pkg: shared field widths, request and status codes and the search
// unit command/response types for the descriptor slot table
// no dependencies
`default_nettype none

package dst_pkg;

	// payload field widths
	localparam int REQ_W      = 3;
	localparam int HANDLE_W   = 32;
	localparam int SLOT_W     = 10;
	localparam int STATUS_W   = 2;
	localparam int HIGH_W     = 11;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 56;

	// widest bitmap word examined by the search unit per cycle
	localparam int MAX_CHUNK = 64;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADOPT  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DUP    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DUP_TO = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_COE    = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADF  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MFILE = 2'd2;

	typedef struct packed {
		logic              start;
		logic              find_high;
		logic [SLOT_W-1:0] from;
	} srch_cmd_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [SLOT_W-1:0] index;
	} srch_rsp_t;

endpackage

`default_nettype wire

>>> hdl/dst_search.sv
// dst_search: multi-cycle priority search over the slot used bitmap,
// one bitmap word per cycle; lowest free at or above a start, or highest used
// depends on dst_pkg
`default_nettype none

module dst_search #(
	parameter int SLOTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOTS-1:0]  used,
	input  dst_pkg::srch_cmd_t cmd,
	output dst_pkg::srch_rsp_t rsp
);
	import dst_pkg::*;

	localparam int CW   = (SLOTS < MAX_CHUNK) ? (2 ** $clog2(SLOTS)) : MAX_CHUNK;
	localparam int NCH  = (SLOTS + CW - 1) / CW;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int OW   = $clog2(CW);
	localparam int PADW = NCH * CW;
	localparam logic [CHW-1:0]  LAST_CH = CHW'(NCH - 1);
	localparam logic [SLOT_W:0] SLOTS_V = (SLOT_W + 1)'(SLOTS);

	logic [PADW-1:0] busy_map;
	logic [PADW-1:0] set_map;
	logic            busy_q;
	logic            high_q;
	logic [CHW-1:0]  chunk_q;
	logic [OW-1:0]   lo_q;
	srch_rsp_t       rsp_q;
	logic [CW-1:0]   word;
	logic [CW-1:0]   cand;
	logic            hit;
	logic            at_end;
	logic [OW-1:0]   off;
	logic [SLOT_W-1:0] found_idx;

	function automatic logic [OW-1:0] enc_low(input logic [CW-1:0] v);
		logic [OW-1:0] r;
		r = '0;
		for (int i = CW - 1; i >= 0; i--) begin
			if (v[i]) r = OW'(i);
		end
		return r;
	endfunction

	function automatic logic [OW-1:0] enc_high(input logic [CW-1:0] v);
		logic [OW-1:0] r;
		r = '0;
		for (int i = 0; i < CW; i++) begin
			if (v[i]) r = OW'(i);
		end
		return r;
	endfunction

	// pad bits beyond the table: busy for the free search, clear for the used search
	generate
		if (PADW > SLOTS) begin : g_pad
			assign busy_map = {{(PADW - SLOTS){1'b1}}, used};
			assign set_map  = {{(PADW - SLOTS){1'b0}}, used};
		end else begin : g_nopad
			assign busy_map = used;
			assign set_map  = used;
		end
	endgenerate

	always_comb begin
		word      = high_q ? set_map[chunk_q * CW +: CW] : ~busy_map[chunk_q * CW +: CW];
		cand      = word & ({CW{1'b1}} << lo_q);
		hit       = |cand;
		off       = high_q ? enc_high(cand) : enc_low(cand);
		at_end    = high_q ? (chunk_q == '0) : (chunk_q == LAST_CH);
		found_idx = SLOT_W'({chunk_q, off});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			high_q  <= 1'b0;
			chunk_q <= '0;
			lo_q    <= '0;
			rsp_q   <= '0;
		end else begin
			if (cmd.start) begin
				high_q <= cmd.find_high;
				if (cmd.find_high) begin
					chunk_q    <= LAST_CH;
					lo_q       <= '0;
					busy_q     <= 1'b1;
					rsp_q.done <= 1'b0;
				end else if ({1'b0, cmd.from} >= SLOTS_V) begin
					// start beyond the table: nothing to find
					lo_q   <= '0;
					busy_q <= 1'b0;
					rsp_q  <= '{done: 1'b1, found: 1'b0, index: '0};
				end else begin
					chunk_q    <= CHW'(cmd.from >> OW);
					lo_q       <= cmd.from[OW-1:0];
					busy_q     <= 1'b1;
					rsp_q.done <= 1'b0;
				end
			end else if (busy_q) begin
				if (hit) begin
					busy_q <= 1'b0;
					rsp_q  <= '{done: 1'b1, found: 1'b1, index: found_idx};
				end else if (at_end) begin
					busy_q <= 1'b0;
					rsp_q  <= '{done: 1'b1, found: 1'b0, index: '0};
				end else begin
					chunk_q    <= high_q ? (chunk_q - 1'b1) : (chunk_q + 1'b1);
					lo_q       <= '0;
					rsp_q.done <= 1'b0;
				end
			end else begin
				rsp_q.done <= 1'b0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> hdl/descriptor_slot_table_top.sv
// descriptor_slot_table_top: request sequencer, handle memory, used/keep
// bitmaps and output register of the descriptor slot table
// depends on dst_pkg and dst_search
//
// usage:
//   requests enter on the s_axis channel, one transaction per request; the
//   request kind rides in s_axis_tuser, its operands in s_axis_tdata
//   each request returns exactly one result transaction on m_axis
//   requests are served one at a time: s_axis_tready is high only while the
//   sequencer is idle; a finished result sits in the output register, so the
//   next request is taken while that result waits for m_axis_tready
//   bad descriptors and unknown requests go from decode straight to the final
//   state; lookup passes through the capture state, dup_to through the read
//   states S_RDT and S_RDS, close through capture and then the search; adopt,
//   dup and close_on_exec go through the search, which walks the bitmap one
//   word at a time (64 slots per word, at most SLOTS/64 words, 4 words at 256 slots)
//   the handle memory has one read and one write port with registered read
//   data; dup_to reads its target and then its source through that one port
//   reset clears the used and keep bitmaps, sets the highest used slot to -1
//   and empties the output register; the handle memory is not cleared, since
//   an entry is only reported or copied once its used bit shows it was written
//   when the receiver stalls, the result is held and the sequencer waits in
//   its final state until the output register frees up
`default_nettype none

module descriptor_slot_table_top #(
	parameter int SLOTS       = 256,
	parameter int HANDLE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// handle, keep_on_exec, slot_index, min_slot, target_slot, zero pad
	input  logic [dst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [dst_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status, slot_out, handle_out, highest_used, zero pad
	output logic [dst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// handle_valid
	output logic [0:0]                       m_axis_tuser
);
	import dst_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam logic [SLOT_W:0] SLOTS_V = (SLOT_W + 1)'(SLOTS);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0; // waiting for a request
	localparam logic [2:0] S_DEC  = 3'd1; // source check, first memory read
	localparam logic [2:0] S_SRCH = 3'd2; // waiting on the bitmap search
	localparam logic [2:0] S_RDT  = 3'd3; // dup_to: displaced handle arrives
	localparam logic [2:0] S_RDS  = 3'd4; // dup_to: source handle arrives, write back
	localparam logic [2:0] S_CAP  = 3'd5; // lookup/close: handle arrives
	localparam logic [2:0] S_DONE = 3'd6; // result waits for the output register

	logic [2:0]          state_q;
	logic [REQ_W-1:0]    req_q;
	logic [HW-1:0]       hnd_q;
	logic                keep_in_q;
	logic [SLOT_W-1:0]   src_q;
	logic [SLOT_W-1:0]   min_q;
	logic [SLOT_W-1:0]   tgt_q;

	logic [SLOTS-1:0]    used_q;
	logic [SLOTS-1:0]    keep_q;
	logic signed [SW:0]  highest_q;

	// handle memory
	logic [HW-1:0]       mem [SLOTS];
	logic [HW-1:0]       rdata_q;
	logic                rd_en;
	logic [SW-1:0]       rd_addr;
	logic                wr_en;
	logic [SW-1:0]       wr_addr;
	logic [HW-1:0]       wr_data;

	// result being built
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [HANDLE_W-1:0] res_hnd_q;
	logic                res_hv_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic                   out_user_q;

	srch_cmd_t           srch_cmd;
	srch_rsp_t           srch_rsp;

	logic [SW-1:0]       src_a;
	logic [SW-1:0]       tgt_a;
	logic [SW-1:0]       fidx;
	logic                src_ok;
	logic                tgt_in;
	logic signed [SW:0]  f_s;
	logic signed [SW:0]  tgt_s;
	logic signed [HIGH_W-1:0] high_ext;

	assign src_a    = src_q[SW-1:0];
	assign tgt_a    = tgt_q[SW-1:0];
	assign fidx     = srch_rsp.index[SW-1:0];
	assign src_ok   = ({1'b0, src_q} < SLOTS_V) && used_q[src_a];
	assign tgt_in   = ({1'b0, tgt_q} < SLOTS_V);
	assign f_s      = $signed({1'b0, fidx});
	assign tgt_s    = $signed({1'b0, tgt_a});
	assign high_ext = HIGH_W'(highest_q);

	dst_search #(
		.SLOTS (SLOTS)
	) u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.used   (used_q),
		.cmd    (srch_cmd),
		.rsp    (srch_rsp)
	);

	// memory port and search command steering
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = src_a;
		wr_en    = 1'b0;
		wr_addr  = fidx;
		wr_data  = hnd_q;
		srch_cmd = '0;
		unique case (state_q)
			S_DEC: begin
				unique case (req_q)
					REQ_ADOPT: begin
						srch_cmd = '{start: 1'b1, find_high: 1'b0, from: '0};
					end
					REQ_LOOKUP, REQ_CLOSE: begin
						rd_en = src_ok;
					end
					REQ_DUP: begin
						rd_en    = src_ok;
						srch_cmd = '{start: src_ok, find_high: 1'b0, from: min_q};
					end
					REQ_DUP_TO: begin
						rd_en   = src_ok && tgt_in;
						rd_addr = tgt_a;
					end
					REQ_COE: begin
						// bitmap is cleared on this edge, search sees the new map
						srch_cmd = '{start: 1'b1, find_high: 1'b1, from: '0};
					end
					default: begin
					end
				endcase
			end
			S_RDT: begin
				rd_en   = 1'b1;
				rd_addr = src_a;
			end
			S_RDS: begin
				wr_en   = 1'b1;
				wr_addr = tgt_a;
				wr_data = rdata_q;
			end
			S_CAP: begin
				if (req_q == REQ_CLOSE) begin
					srch_cmd = '{start: 1'b1, find_high: 1'b1, from: '0};
				end
			end
			S_SRCH: begin
				if (srch_rsp.done && srch_rsp.found) begin
					if (req_q == REQ_ADOPT) begin
						wr_en = 1'b1;
					end else if (req_q == REQ_DUP) begin
						wr_en   = 1'b1;
						wr_data = rdata_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// sequencer, bitmaps and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			hnd_q        <= '0;
			keep_in_q    <= 1'b0;
			src_q        <= '0;
			min_q        <= '0;
			tgt_q        <= '0;
			used_q       <= '0;
			keep_q       <= '0;
			highest_q    <= '1;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_hnd_q    <= '0;
			res_hv_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_user_q   <= 1'b0;
		end else begin
			// the final state reloads the output register on its own
			if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_q        <= s_axis_tuser;
						hnd_q        <= s_axis_tdata[HW-1:0];
						keep_in_q    <= s_axis_tdata[32];
						src_q        <= s_axis_tdata[42:33];
						min_q        <= s_axis_tdata[52:43];
						tgt_q        <= s_axis_tdata[62:53];
						res_status_q <= ST_OK;
						res_slot_q   <= '0;
						res_hnd_q    <= '0;
						res_hv_q     <= 1'b0;
						state_q      <= S_DEC;
					end
				end
				S_DEC: begin
					unique case (req_q)
						REQ_ADOPT: begin
							state_q <= S_SRCH;
						end
						REQ_LOOKUP, REQ_CLOSE: begin
							if (!src_ok) begin
								res_status_q <= ST_BADF;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_CAP;
							end
						end
						REQ_DUP: begin
							if (!src_ok) begin
								res_status_q <= ST_BADF;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_SRCH;
							end
						end
						REQ_DUP_TO: begin
							if (!src_ok) begin
								res_status_q <= ST_BADF;
								state_q      <= S_DONE;
							end else if (!tgt_in) begin
								res_status_q <= ST_MFILE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_RDT;
							end
						end
						REQ_COE: begin
							used_q  <= used_q & keep_q;
							state_q <= S_SRCH;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_CAP: begin
					res_hnd_q <= HANDLE_W'(rdata_q);
					res_hv_q  <= 1'b1;
					if (req_q == REQ_CLOSE) begin
						used_q[src_a] <= 1'b0;
						keep_q[src_a] <= 1'b0;
						state_q       <= S_SRCH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RDT: begin
					// target contents are only reported if the slot was open
					if (used_q[tgt_a]) begin
						res_hnd_q <= HANDLE_W'(rdata_q);
						res_hv_q  <= 1'b1;
					end
					state_q <= S_RDS;
				end
				S_RDS: begin
					used_q[tgt_a] <= 1'b1;
					keep_q[tgt_a] <= keep_q[src_a];
					if (tgt_s > highest_q) begin
						highest_q <= tgt_s;
					end
					res_slot_q <= tgt_q;
					state_q    <= S_DONE;
				end
				S_SRCH: begin
					if (srch_rsp.done) begin
						state_q <= S_DONE;
						if (req_q == REQ_ADOPT || req_q == REQ_DUP) begin
							if (srch_rsp.found) begin
								used_q[fidx] <= 1'b1;
								keep_q[fidx] <= (req_q == REQ_ADOPT) ? keep_in_q : keep_q[src_a];
								if (f_s > highest_q) begin
									highest_q <= f_s;
								end
								res_slot_q <= srch_rsp.index;
							end else begin
								res_status_q <= ST_MFILE;
							end
						end else begin
							// trim after close or close_on_exec
							highest_q <= srch_rsp.found ? f_s : '1;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {1'b0, high_ext, res_hnd_q, res_slot_q, res_status_q};
						out_user_q  <= res_hv_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready   = (state_q == S_IDLE);
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;

	// search responses only arrive while the sequencer waits on them
	a_srch_done_in_srch: assert property (@(posedge clk) disable iff (!arst_n)
		srch_rsp.done |-> (state_q == S_SRCH))
		else $error("search response outside search state");

	// an idle table reports -1 exactly when no slot is open
	a_highest_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((highest_q[SW] == 1'b1) == (used_q == '0)))
		else $error("highest used slot disagrees with used bitmap");

	// a keep bit never survives on a free slot
	a_keep_subset: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> ((keep_q & ~used_q) == '0))
		else $error("keep bit set on a free slot");

	// the handle memory is written only on an allocation
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SRCH || state_q == S_RDS))
		else $error("handle memory written outside an allocation");

endmodule

`default_nettype wire
